@@ rtl/core/mfd_pkg.sv @@
`default_nettype none

package mfd_pkg;

    localparam int MAX_CHANNELS = 10;
    localparam int HIST_DEPTH   = 2 * MAX_CHANNELS + 4;
    localparam int HIGH_SHIFT   = 5;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int ADDR_W       = 5;

    localparam logic [2:0] REG_NARROW_MODE   = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_MARKER_A      = 3'd2;
    localparam logic [2:0] REG_MARKER_B      = 3'd3;
    localparam logic [2:0] REG_MARKER_C      = 3'd4;
    localparam logic [2:0] REG_MARKER_D      = 3'd5;
    localparam logic [2:0] REG_NARROW_START  = 3'd6;
    localparam logic [2:0] REG_NARROW_END    = 3'd7;

    typedef struct packed {
        logic       narrow_mode;
        logic [3:0] channel_count;
        logic [7:0] marker_a;
        logic [7:0] marker_b;
        logic [7:0] marker_c;
        logic [7:0] marker_d;
        logic [7:0] narrow_start;
        logic [7:0] narrow_end;
    } t_cfg;

    function automatic logic [CNT_W-1:0] eff_channels(input logic [3:0] cc);
        logic [CNT_W-1:0] r;
        if (cc == 4'd0) begin
            r = CNT_W'(1);
        end else if (int'(cc) > MAX_CHANNELS) begin
            r = CNT_W'(MAX_CHANNELS);
        end else begin
            r = CNT_W'(cc);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mfd_cfg.sv @@
`default_nettype none

module mfd_cfg
    import mfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic w_hit;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_hit  = (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.narrow_mode   <= 1'b0;
            r_cfg.channel_count <= 4'd10;
            r_cfg.marker_a      <= 8'd10;
            r_cfg.marker_b      <= 8'd5;
            r_cfg.marker_c      <= 8'd0;
            r_cfg.marker_d      <= 8'd15;
            r_cfg.narrow_start  <= 8'd240;
            r_cfg.narrow_end    <= 8'd90;
        end else if (w_wr && w_hit) begin
            case (paddr[4:2])
                REG_NARROW_MODE:   r_cfg.narrow_mode   <= pwdata[0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[3:0];
                REG_MARKER_A:      r_cfg.marker_a      <= pwdata[7:0];
                REG_MARKER_B:      r_cfg.marker_b      <= pwdata[7:0];
                REG_MARKER_C:      r_cfg.marker_c      <= pwdata[7:0];
                REG_MARKER_D:      r_cfg.marker_d      <= pwdata[7:0];
                REG_NARROW_START:  r_cfg.narrow_start  <= pwdata[7:0];
                REG_NARROW_END:    r_cfg.narrow_end    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (w_hit) begin
            case (paddr[4:2])
                REG_NARROW_MODE:   prdata = {31'd0, r_cfg.narrow_mode};
                REG_CHANNEL_COUNT: prdata = {28'd0, r_cfg.channel_count};
                REG_MARKER_A:      prdata = {24'd0, r_cfg.marker_a};
                REG_MARKER_B:      prdata = {24'd0, r_cfg.marker_b};
                REG_MARKER_C:      prdata = {24'd0, r_cfg.marker_c};
                REG_MARKER_D:      prdata = {24'd0, r_cfg.marker_d};
                REG_NARROW_START:  prdata = {24'd0, r_cfg.narrow_start};
                REG_NARROW_END:    prdata = {24'd0, r_cfg.narrow_end};
                default:           prdata = 32'd0;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/mfd_hist_cell.sv @@
`default_nettype none

module mfd_hist_cell
    import mfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_flag,
    output logic      [7:0] o_byte,
    output logic            o_flag
);

    logic [7:0] r_byte;
    logic       r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
            r_flag <= 1'b0;
        end else if (i_shift) begin
            r_byte <= i_byte;
            r_flag <= i_flag;
        end
    end

    assign o_byte = r_byte;
    assign o_flag = r_flag;

endmodule

`default_nettype wire

@@ rtl/core/mfd_out_cell.sv @@
`default_nettype none

module mfd_out_cell
    import mfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_load,
    input  wire logic [12:0] i_load_value,
    input  wire logic        i_shift,
    input  wire logic [12:0] i_next_value,
    output logic      [12:0] o_value
);

    logic [12:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_load_value;
        end else if (i_shift) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ rtl/core/marker_framed_sample_deframer.sv @@
// Marker-framed sample deframer.
// Input channel: i_rx_valid / o_rx_stall carry one received byte (i_rx_byte)
// per item. Output channel: o_smp_valid / i_smp_stall carry one decoded
// sample (o_sample_value, o_channel_index, o_frame_last) per item.
// Received bytes shift through a row of history cells, one byte per cell.
// Bytes that do not close a frame are always taken at one per cycle, also
// while samples wait on the output. A byte that closes a frame loads all
// N samples of the frame into a row of output cells in the cycle it is
// taken; the first sample is shown the next cycle, then one per cycle as
// the receiver takes them. A closing byte is stalled only while samples of
// an earlier frame remain (it may enter as the last one is taken).
// Receiver stall holds the current sample and the rest of the row.
// Reset clears the history to zero bytes with no marker flags, empties the
// output row and restores the register defaults. The user must write the
// APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module marker_framed_sample_deframer
    import mfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rx_valid,
    output logic                   o_rx_stall,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_smp_valid,
    input  wire logic              i_smp_stall,
    output logic      [12:0]       o_sample_value,
    output logic      [3:0]        o_channel_index,
    output logic                   o_frame_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg              w_cfg;
    logic [7:0]        w_hbyte [HIST_DEPTH];
    logic              w_hflag [HIST_DEPTH];
    logic [12:0]       w_lane  [MAX_CHANNELS];
    logic [12:0]       w_oval  [MAX_CHANNELS];
    logic [CNT_W-1:0]  w_n;
    logic              w_marker_here;
    logic              w_far_flag;
    logic [7:0]        w_start_tap;
    logic              w_trig;
    logic              w_free;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_load;
    logic [CNT_W-1:0]  r_cnt;
    logic [3:0]        r_idx;

    mfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_n = eff_channels(w_cfg.channel_count);

    assign w_marker_here = (i_rx_byte == w_cfg.marker_d) && (w_hbyte[0] == w_cfg.marker_c)
                        && (w_hbyte[1] == w_cfg.marker_b) && (w_hbyte[2] == w_cfg.marker_a);

    always_comb begin
        w_far_flag  = 1'b0;
        w_start_tap = 8'd0;
        for (int k = 1; k <= MAX_CHANNELS; k++) begin
            if (w_n == CNT_W'(k)) begin
                w_far_flag  = w_hflag[2 * k + 3];
                w_start_tap = w_hbyte[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            w_lane[i] = 13'd0;
            for (int k = 1; k <= MAX_CHANNELS; k++) begin
                if ((w_n == CNT_W'(k)) && (i < k)) begin
                    if (w_cfg.narrow_mode) begin
                        w_lane[i] = {5'd0, w_hbyte[k - 1 - i]};
                    end else begin
                        w_lane[i] = (13'(w_hbyte[2 * k + 1 - 2 * i]) << HIGH_SHIFT)
                                  | {5'd0, w_hbyte[2 * k + 2 - 2 * i]};
                    end
                end
            end
        end
    end

    assign w_trig = w_cfg.narrow_mode
                  ? ((i_rx_byte == w_cfg.narrow_end) && (w_start_tap == w_cfg.narrow_start))
                  : (w_marker_here && w_far_flag);

    assign o_smp_valid = (r_cnt != '0);
    assign w_out_acc   = o_smp_valid & ~i_smp_stall;
    assign w_free      = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_out_acc);
    assign o_rx_stall  = w_trig & ~w_free;
    assign w_in_acc    = i_rx_valid & ~o_rx_stall;
    assign w_load      = w_in_acc & w_trig;

    for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_hist
        if (j == 0) begin : g_head
            mfd_hist_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_acc),
                .i_byte  (i_rx_byte),
                .i_flag  (w_marker_here),
                .o_byte  (w_hbyte[j]),
                .o_flag  (w_hflag[j])
            );
        end else begin : g_body
            mfd_hist_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_acc),
                .i_byte  (w_hbyte[j - 1]),
                .i_flag  (w_hflag[j - 1]),
                .o_byte  (w_hbyte[j]),
                .o_flag  (w_hflag[j])
            );
        end
    end

    for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_out
        if (j == MAX_CHANNELS - 1) begin : g_tail
            mfd_out_cell u_cell (
                .i_clk        (i_clk),
                .i_load       (w_load),
                .i_load_value (w_lane[j]),
                .i_shift      (w_out_acc),
                .i_next_value (13'd0),
                .o_value      (w_oval[j])
            );
        end else begin : g_body
            mfd_out_cell u_cell (
                .i_clk        (i_clk),
                .i_load       (w_load),
                .i_load_value (w_lane[j]),
                .i_shift      (w_out_acc),
                .i_next_value (w_oval[j + 1]),
                .o_value      (w_oval[j])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= 4'd0;
        end else if (w_load) begin
            r_cnt <= w_n;
            r_idx <= 4'd0;
        end else if (w_out_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_idx <= r_idx + 4'd1;
        end
    end

    assign o_sample_value  = w_oval[0];
    assign o_channel_index = r_idx;
    assign o_frame_last    = (r_cnt == CNT_W'(1));

endmodule

`default_nettype wire
